### design/priority_ring_buffer_assert.svh
// Assertion macros for the priority ring buffer
`ifndef PRIORITY_RING_BUFFER_ASSERT_SVH
`define PRIORITY_RING_BUFFER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PRB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/prb_pkg.sv
// Shared types, constants and helpers for the priority ring buffer
package prb_pkg;

    localparam int DEPTH = 64;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam ptr_t LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam cnt_t FULL_CNT  = CNT_W'(DEPTH);

    localparam logic [1:0] CMD_STORE     = 2'd0;
    localparam logic [1:0] CMD_READ_OLD  = 2'd1;
    localparam logic [1:0] CMD_READ_PRIO = 2'd2;

    localparam logic [1:0] PRIO_MEDIUM = 2'd1;

    typedef struct packed {
        logic [31:0] topic;
        logic [31:0] message;
        logic [1:0]  prio;
        logic [31:0] stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic first;
        logic compare;
    } cmp_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIFO_RD,
        ST_SCAN,
        ST_SHIFT_START,
        ST_SHIFT,
        ST_DONE
    } state_t;

    function automatic ptr_t next_slot(ptr_t p);
        return (p == LAST_SLOT) ? '0 : ptr_t'(p + 1'b1);
    endfunction

    function automatic ptr_t prev_slot(ptr_t p);
        return (p == '0) ? LAST_SLOT : ptr_t'(p - 1'b1);
    endfunction

endpackage

### design/prb_ram.sv
// Generic simple dual-port RAM with registered read
module prb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/prb_cmp.sv
// Shared priority compare unit holding the best entry seen in a scan
module prb_cmp (
    input  logic               clk,
    input  prb_pkg::cmp_ctrl_t ctrl,
    input  prb_pkg::entry_t    cand_entry,
    input  prb_pkg::ptr_t      cand_slot,
    output prb_pkg::entry_t    best_entry,
    output prb_pkg::ptr_t      best_slot
);

    prb_pkg::entry_t best_entry_reg;
    prb_pkg::entry_t best_entry_next;
    prb_pkg::ptr_t   best_slot_reg;
    prb_pkg::ptr_t   best_slot_next;
    logic            take;

    // strict less-than keeps the oldest of equal priorities
    always_comb
    begin
        take = ctrl.first || (ctrl.compare && (cand_entry.prio < best_entry_reg.prio));
        best_entry_next = take ? cand_entry : best_entry_reg;
        best_slot_next  = take ? cand_slot : best_slot_reg;
    end

    always_ff @(posedge clk)
    begin
        best_entry_reg <= best_entry_next;
        best_slot_reg  <= best_slot_next;
    end

    assign best_entry = best_entry_reg;
    assign best_slot  = best_slot_reg;

endmodule

### design/priority_ring_buffer.sv
// Top level of the priority ring buffer: sequencer, pointers and output register
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  input    | in_valid / in_ready  | command, topic_handle, message_handle,
//           |                      | priority_req, timestamp_now
//  result   | out_valid / out_ready| entry_valid, out_topic_handle, out_message_handle,
//           |                      | out_priority, out_timestamp, overwrote_oldest, fill_level
//
// Store and empty read go from ST_IDLE to ST_DONE; oldest read passes ST_FIFO_RD.
// Priority read scans the n entries held and shifts s slots to close the gap; its
// length is set by the single read and single write port of the entry RAM.
// One request at a time; a finished result sits in the output register while the
// next request is taken. Async reset clears pointers and count; no clearing pass.
module priority_ring_buffer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 command,
    input  logic [31:0]                topic_handle,
    input  logic [31:0]                message_handle,
    input  logic [1:0]                 priority_req,
    input  logic [31:0]                timestamp_now,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       entry_valid,
    output logic [31:0]                out_topic_handle,
    output logic [31:0]                out_message_handle,
    output logic [1:0]                 out_priority,
    output logic [31:0]                out_timestamp,
    output logic                       overwrote_oldest,
    output logic [prb_pkg::CNT_W-1:0]  fill_level
);

    `include "priority_ring_buffer_assert.svh"

    prb_pkg::state_t state_reg, state_next;
    prb_pkg::ptr_t   wr_ptr_reg, wr_ptr_next;
    prb_pkg::ptr_t   rd_ptr_reg, rd_ptr_next;
    prb_pkg::cnt_t   count_reg, count_next;
    prb_pkg::cnt_t   iss_cnt_reg, iss_cnt_next;
    prb_pkg::cnt_t   rcv_cnt_reg, rcv_cnt_next;
    prb_pkg::ptr_t   scan_addr_reg, scan_addr_next;
    prb_pkg::ptr_t   data_slot_reg, data_slot_next;
    prb_pkg::ptr_t   cur_reg, cur_next;

    logic            res_valid_reg, res_valid_next;
    prb_pkg::entry_t res_entry_reg, res_entry_next;
    logic            res_ovw_reg, res_ovw_next;
    prb_pkg::cnt_t   res_fill_reg, res_fill_next;

    logic            out_valid_reg, out_valid_next;
    logic            out_ev_reg, out_ev_next;
    prb_pkg::entry_t out_entry_reg, out_entry_next;
    logic            out_ovw_reg, out_ovw_next;
    prb_pkg::cnt_t   out_fill_reg, out_fill_next;

    logic                        ram_we;
    prb_pkg::ptr_t               ram_waddr;
    prb_pkg::entry_t             ram_wdata;
    prb_pkg::ptr_t               ram_raddr;
    logic [prb_pkg::ENTRY_W-1:0] ram_rdata;
    prb_pkg::entry_t             rd_entry;

    prb_pkg::cmp_ctrl_t cmp_ctrl;
    prb_pkg::entry_t    best_entry;
    prb_pkg::ptr_t      best_slot;
    prb_pkg::ptr_t      shift_src;
    logic               accept;

    assign in_ready = (state_reg == prb_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign rd_entry = ram_rdata;

    prb_ram #(
        .WIDTH (prb_pkg::ENTRY_W),
        .DEPTH (prb_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    prb_cmp u_cmp (
        .clk        (clk),
        .ctrl       (cmp_ctrl),
        .cand_entry (rd_entry),
        .cand_slot  (data_slot_reg),
        .best_entry (best_entry),
        .best_slot  (best_slot)
    );

    always_comb
    begin
        state_next     = state_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        count_next     = count_reg;
        iss_cnt_next   = iss_cnt_reg;
        rcv_cnt_next   = rcv_cnt_reg;
        scan_addr_next = scan_addr_reg;
        data_slot_next = data_slot_reg;
        cur_next       = cur_reg;
        res_valid_next = res_valid_reg;
        res_entry_next = res_entry_reg;
        res_ovw_next   = res_ovw_reg;
        res_fill_next  = res_fill_reg;
        out_valid_next = out_valid_reg;
        out_ev_next    = out_ev_reg;
        out_entry_next = out_entry_reg;
        out_ovw_next   = out_ovw_reg;
        out_fill_next  = out_fill_reg;
        ram_we         = 1'b0;
        ram_waddr      = wr_ptr_reg;
        ram_wdata      = rd_entry;
        ram_raddr      = rd_ptr_reg;
        cmp_ctrl       = '0;
        shift_src      = prb_pkg::prev_slot(cur_reg);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            prb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_valid_next = 1'b0;
                    res_entry_next = '0;
                    res_ovw_next   = 1'b0;
                    res_fill_next  = count_reg;
                    state_next     = prb_pkg::ST_DONE;
                    case (command)
                        prb_pkg::CMD_STORE:
                        begin
                            ram_we          = 1'b1;
                            ram_wdata.topic   = topic_handle;
                            ram_wdata.message = message_handle;
                            ram_wdata.prio    = priority_req;
                            ram_wdata.stamp   = timestamp_now;
                            wr_ptr_next     = prb_pkg::next_slot(wr_ptr_reg);
                            if (count_reg == prb_pkg::FULL_CNT)
                            begin
                                rd_ptr_next  = prb_pkg::next_slot(rd_ptr_reg);
                                res_ovw_next = 1'b1;
                            end
                            else
                            begin
                                count_next    = prb_pkg::cnt_t'(count_reg + 1'b1);
                                res_fill_next = prb_pkg::cnt_t'(count_reg + 1'b1);
                            end
                        end
                        prb_pkg::CMD_READ_OLD,
                        prb_pkg::CMD_READ_PRIO:
                        begin
                            if (count_reg == '0)
                            begin
                                res_entry_next.prio = prb_pkg::PRIO_MEDIUM;
                            end
                            else if (command == prb_pkg::CMD_READ_OLD)
                            begin
                                state_next = prb_pkg::ST_FIFO_RD;
                            end
                            else
                            begin
                                iss_cnt_next   = prb_pkg::cnt_t'(1);
                                rcv_cnt_next   = '0;
                                scan_addr_next = prb_pkg::next_slot(rd_ptr_reg);
                                data_slot_next = rd_ptr_reg;
                                state_next     = prb_pkg::ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            prb_pkg::ST_FIFO_RD:
            begin
                res_valid_next = 1'b1;
                res_entry_next = rd_entry;
                rd_ptr_next    = prb_pkg::next_slot(rd_ptr_reg);
                count_next     = prb_pkg::cnt_t'(count_reg - 1'b1);
                res_fill_next  = prb_pkg::cnt_t'(count_reg - 1'b1);
                state_next     = prb_pkg::ST_DONE;
            end

            prb_pkg::ST_SCAN:
            begin
                cmp_ctrl.first   = (rcv_cnt_reg == '0);
                cmp_ctrl.compare = 1'b1;
                rcv_cnt_next     = prb_pkg::cnt_t'(rcv_cnt_reg + 1'b1);
                if (iss_cnt_reg < count_reg)
                begin
                    ram_raddr      = scan_addr_reg;
                    iss_cnt_next   = prb_pkg::cnt_t'(iss_cnt_reg + 1'b1);
                    data_slot_next = scan_addr_reg;
                    scan_addr_next = prb_pkg::next_slot(scan_addr_reg);
                end
                if (prb_pkg::cnt_t'(rcv_cnt_reg + 1'b1) == count_reg)
                begin
                    state_next = prb_pkg::ST_SHIFT_START;
                end
            end

            prb_pkg::ST_SHIFT_START:
            begin
                if (best_slot == rd_ptr_reg)
                begin
                    res_valid_next = 1'b1;
                    res_entry_next = best_entry;
                    rd_ptr_next    = prb_pkg::next_slot(rd_ptr_reg);
                    count_next     = prb_pkg::cnt_t'(count_reg - 1'b1);
                    res_fill_next  = prb_pkg::cnt_t'(count_reg - 1'b1);
                    state_next     = prb_pkg::ST_DONE;
                end
                else
                begin
                    ram_raddr  = prb_pkg::prev_slot(best_slot);
                    cur_next   = best_slot;
                    state_next = prb_pkg::ST_SHIFT;
                end
            end

            prb_pkg::ST_SHIFT:
            begin
                // move the older neighbor into the gap, fetch the next one
                ram_we    = 1'b1;
                ram_waddr = cur_reg;
                ram_wdata = rd_entry;
                if (shift_src == rd_ptr_reg)
                begin
                    res_valid_next = 1'b1;
                    res_entry_next = best_entry;
                    rd_ptr_next    = prb_pkg::next_slot(rd_ptr_reg);
                    count_next     = prb_pkg::cnt_t'(count_reg - 1'b1);
                    res_fill_next  = prb_pkg::cnt_t'(count_reg - 1'b1);
                    state_next     = prb_pkg::ST_DONE;
                end
                else
                begin
                    ram_raddr = prb_pkg::prev_slot(shift_src);
                    cur_next  = shift_src;
                end
            end

            prb_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_ev_next    = res_valid_reg;
                    out_entry_next = res_entry_reg;
                    out_ovw_next   = res_ovw_reg;
                    out_fill_next  = res_fill_reg;
                    state_next     = prb_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = prb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= prb_pkg::ST_IDLE;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            iss_cnt_reg   <= '0;
            rcv_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
            iss_cnt_reg   <= iss_cnt_next;
            rcv_cnt_reg   <= rcv_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_addr_reg <= scan_addr_next;
        data_slot_reg <= data_slot_next;
        cur_reg       <= cur_next;
        res_valid_reg <= res_valid_next;
        res_entry_reg <= res_entry_next;
        res_ovw_reg   <= res_ovw_next;
        res_fill_reg  <= res_fill_next;
        out_ev_reg    <= out_ev_next;
        out_entry_reg <= out_entry_next;
        out_ovw_reg   <= out_ovw_next;
        out_fill_reg  <= out_fill_next;
    end

    assign out_valid          = out_valid_reg;
    assign entry_valid        = out_ev_reg;
    assign out_topic_handle   = out_entry_reg.topic;
    assign out_message_handle = out_entry_reg.message;
    assign out_priority       = out_entry_reg.prio;
    assign out_timestamp      = out_entry_reg.stamp;
    assign overwrote_oldest   = out_ovw_reg;
    assign fill_level         = out_fill_reg;

    `PRB_ASSERT_NOW(a_count_max, 1'b1, count_reg <= prb_pkg::FULL_CNT, "entry count above depth")
    `PRB_ASSERT_NEXT(a_store_full_ovw, accept && command == prb_pkg::CMD_STORE && count_reg == prb_pkg::FULL_CNT, res_ovw_reg && res_fill_reg == prb_pkg::FULL_CNT, "full store did not report overwrite")
    `PRB_ASSERT_NEXT(a_empty_read, accept && (command == prb_pkg::CMD_READ_OLD || command == prb_pkg::CMD_READ_PRIO) && count_reg == '0, !res_valid_reg && res_entry_reg.prio == prb_pkg::PRIO_MEDIUM, "empty read result wrong")

endmodule
